// File: rtl/assert_macros.svh
// Assertion helpers; every check is clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/iurc_pkg.sv
package iurc_pkg;

    localparam logic [7:0]  UDP_PROTO    = 8'd17;
    localparam logic [15:0] MIN_FRAME    = 16'd28;
    localparam logic [15:0] IP_HDR_LEN   = 16'd20;
    localparam logic [3:0]  IP_VERSION   = 4'd4;
    localparam logic [3:0]  IP_IHL       = 4'd5;

    // byte offsets within the frame
    localparam logic [15:0] IDX_VER_IHL   = 16'd0;
    localparam logic [15:0] IDX_TOT_LEN   = 16'd3;
    localparam logic [15:0] IDX_LEN_FIELD = 16'd4;
    localparam logic [15:0] IDX_PROTO     = 16'd9;
    localparam logic [15:0] IDX_HDR_CHK   = 16'd11;
    localparam logic [15:0] IDX_PSEUDO    = 16'd12;
    localparam logic [15:0] IDX_DST_PORT  = 16'd23;
    localparam logic [15:0] IDX_UDP_LEN   = 16'd25;
    localparam logic [15:0] IDX_UDP_CHK   = 16'd27;

    localparam int          CFG_IDX_W       = 8;
    localparam logic [7:0]  CFG_CLIENT_PORT = 8'd0;
    localparam logic [7:0]  CFG_MAX_LEN     = 8'd1;
    localparam logic [15:0] CLIENT_PORT_RST = 16'd68;
    localparam logic [15:0] MAX_LEN_RST     = 16'd576;
    localparam logic [15:0] ALL_ONES        = 16'hffff;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_UNRELATED = 3'd3,
        ST_BAD_IPCHK = 3'd4,
        ST_BAD_UDPCHK = 3'd5
    } t_status;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] header_sum;
        logic [15:0] udp_sum;
        logic [7:0]  held_high_byte;
        logic [7:0]  ver_ihl_byte;
        logic [7:0]  proto_byte;
        logic [15:0] total_length;
        logic [15:0] udp_dest_port;
        logic [15:0] udp_length;
        logic [15:0] rx_header_check;
        logic [15:0] rx_udp_check;
    } t_frame;

    typedef struct packed {
        t_status     status;
        logic [15:0] payload_len;
    } t_result;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: rtl/iurc_frame_acc.sv
module iurc_frame_acc
    import iurc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    input  logic [15:0] i_max_len,
    output t_frame      o_frame,
    output t_frame      o_next
);

    t_frame      r_frame;
    t_frame      n_frame;
    logic [15:0] idx;
    logic [15:0] word;
    logic        in_window;
    logic        take;

    assign idx       = r_frame.byte_count;
    assign word      = {r_frame.held_high_byte, i_data};
    assign in_window = idx < i_max_len;
    // the length field itself always has to be read
    assign take      = in_window && ((idx < IDX_LEN_FIELD) || (idx < r_frame.total_length));

    always_comb begin
        n_frame = r_frame;
        if (in_window) begin
            n_frame.byte_count = idx + 16'd1;
        end
        if (take) begin
            if (idx == IDX_VER_IHL) begin
                n_frame.ver_ihl_byte = i_data;
            end
            if (idx == IDX_PROTO) begin
                n_frame.proto_byte = i_data;
            end
            if (!idx[0]) begin
                n_frame.held_high_byte = i_data;
            end else begin
                if (idx == IDX_TOT_LEN)  n_frame.total_length    = word;
                if (idx == IDX_HDR_CHK)  n_frame.rx_header_check = word;
                if (idx == IDX_DST_PORT) n_frame.udp_dest_port   = word;
                if (idx == IDX_UDP_LEN)  n_frame.udp_length      = word;
                if (idx == IDX_UDP_CHK)  n_frame.rx_udp_check    = word;
                if (idx < IP_HDR_LEN && idx != IDX_HDR_CHK) begin
                    n_frame.header_sum = oc_add(r_frame.header_sum, word);
                end
                if (idx >= IDX_PSEUDO && idx != IDX_UDP_CHK) begin
                    n_frame.udp_sum = oc_add(r_frame.udp_sum, word);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_en) begin
            r_frame <= i_last ? '0 : n_frame;
        end
    end

    assign o_frame = r_frame;
    assign o_next  = n_frame;

endmodule

// File: rtl/ipv4_udp_receive_checker_unit.sv
// IPv4/UDP receive checker.
// Slave stream: one frame byte per item in tdata, starting at the IP header,
// tlast on the final byte of the frame. Master stream: one verdict item per
// frame, tdata = status[2:0], payload_len[18:3] (ok only, else zero).
// Config channel: index 0 client_port, index 1 max_packet_len; always ready.
// Users must write it only while no frame is in flight; the block does not enforce it.
// Throughput: one byte per cycle while o_s_tready is high. Each byte passes an
// input register and the running-sum update; the tlast byte freezes the frame
// fields into a snapshot register and the verdict logic loads the output
// register from it.
// The snapshot and output registers let the next frame stream in while a
// verdict waits; if the receiver holds tready low, bytes keep flowing until a
// second tlast reaches the input register, then tready drops.
// Reset (synchronous, active low) clears frame state, empties the pipeline
// and restores client_port = 68 and max_packet_len = 576.
module ipv4_udp_receive_checker_unit
    import iurc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // data_byte[7:0]
    input  logic                 i_s_tlast,   // last_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [23:0]          o_m_tdata,   // status[2:0], payload_len[18:3], zero[23:19]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

`include "assert_macros.svh"

    logic [15:0] r_client_port;
    logic [15:0] r_max_len;

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;

    logic        r_snap_valid;
    t_frame      r_snap;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    t_frame      w_frame;
    t_frame      w_next;

    logic        out_free;
    logic        snap_free;
    logic        consume;

    assign out_free   = !r_out_valid || i_m_tready;
    assign snap_free  = !r_snap_valid || out_free;
    assign consume    = r_in_valid && (!r_in_last || snap_free);
    assign o_s_tready = !r_in_valid || consume;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_port <= CLIENT_PORT_RST;
            r_max_len     <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CLIENT_PORT) r_client_port <= i_cfg_data;
            if (i_cfg_index == CFG_MAX_LEN)     r_max_len     <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    iurc_frame_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (consume),
        .i_data    (r_in_data),
        .i_last    (r_in_last),
        .i_max_len (r_max_len),
        .o_frame   (w_frame),
        .o_next    (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_free) begin
            r_snap_valid <= consume && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_last) begin
            r_snap <= w_next;
        end
    end

    // verdict on the frozen frame
    always_comb begin
        logic [15:0] s1;
        logic [15:0] s2;
        logic [15:0] s3;
        logic [15:0] calc;
        logic        unrelated;
        logic        udp_bad;
        s1   = oc_add(r_snap.udp_sum, {8'd0, UDP_PROTO});
        s2   = oc_add(s1, r_snap.udp_length);
        s3   = r_snap.total_length[0] ? oc_add(s2, {r_snap.held_high_byte, 8'd0}) : s2;
        calc = ~s3;
        unrelated = (r_snap.proto_byte != UDP_PROTO)
                 || (r_snap.ver_ihl_byte[7:4] != IP_VERSION)
                 || (r_snap.ver_ihl_byte[3:0] != IP_IHL)
                 || (r_snap.udp_dest_port != r_client_port)
                 || (r_snap.udp_length != r_snap.total_length - IP_HDR_LEN)
                 || (r_snap.total_length < MIN_FRAME);
        // zero means no checksum sent; 0xffff stands in for a computed zero
        udp_bad = (r_snap.rx_udp_check != 16'd0) && (r_snap.rx_udp_check != calc)
               && !(calc == 16'd0 && r_snap.rx_udp_check == ALL_ONES);
        n_out.payload_len = 16'd0;
        if (r_snap.byte_count < MIN_FRAME) begin
            n_out.status = ST_SHORT;
        end else if (r_snap.byte_count < r_snap.total_length) begin
            n_out.status = ST_TRUNCATED;
        end else if (unrelated) begin
            n_out.status = ST_UNRELATED;
        end else if (~r_snap.header_sum != r_snap.rx_header_check) begin
            n_out.status = ST_BAD_IPCHK;
        end else if (udp_bad) begin
            n_out.status = ST_BAD_UDPCHK;
        end else begin
            n_out.status      = ST_OK;
            n_out.payload_len = r_snap.total_length - MIN_FRAME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_snap_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.payload_len, r_out.status};

    `ASSERT_ALWAYS(a_len_only_ok,
        !r_out_valid || r_out.status == ST_OK || r_out.payload_len == 16'd0,
        "payload length set on a failed verdict")
    `ASSERT_ALWAYS(a_stall_cause,
        o_s_tready || (r_in_valid && r_in_last && r_snap_valid && r_out_valid),
        "input stalled without a full result path")
    `ASSERT_NEXT(a_frame_cleared,
        consume && r_in_last,
        w_frame.byte_count == 16'd0 && w_frame.total_length == 16'd0,
        "frame state not cleared after a verdict")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

import iurc_pkg::*;

// Expected verdicts: tracks the frame fields and the two running sums the
// same way the block does, and queues one verdict per tlast item.
class verdict_board;
    logic [15:0] client_port;
    logic [15:0] max_len;
    logic [15:0] byte_count;
    logic [15:0] hdr_sum;
    logic [15:0] udp_sum;
    logic [15:0] total_len;
    logic [15:0] dst_port;
    logic [15:0] udp_len;
    logic [15:0] rx_hdr_chk;
    logic [15:0] rx_udp_chk;
    logic [7:0]  held_hi;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    t_result     expected[$];
    int          errors;

    function new();
        client_port = CLIENT_PORT_RST;
        max_len     = MAX_LEN_RST;
        errors      = 0;
        clear_frame();
    endfunction

    static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [31:0] s;
        s = 32'(a) + 32'(b);
        return s[15:0] + s[31:16];
    endfunction

    function void clear_frame();
        byte_count = '0;
        hdr_sum    = '0;
        udp_sum    = '0;
        total_len  = '0;
        dst_port   = '0;
        udp_len    = '0;
        rx_hdr_chk = '0;
        rx_udp_chk = '0;
        held_hi    = '0;
        ver_ihl    = '0;
        proto      = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_CLIENT_PORT: client_port = val;
            CFG_MAX_LEN:     max_len = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected.size();
    endfunction

    function void take_byte(logic [15:0] idx, logic [7:0] d);
        logic [15:0] w;
        if (idx == IDX_VER_IHL) ver_ihl = d;
        if (idx == IDX_PROTO) proto = d;
        if (!idx[0]) begin
            held_hi = d;
        end else begin
            w = {held_hi, d};
            if (idx == IDX_TOT_LEN) total_len = w;
            if (idx == IDX_HDR_CHK) rx_hdr_chk = w;
            if (idx == IDX_DST_PORT) dst_port = w;
            if (idx == IDX_UDP_LEN) udp_len = w;
            if (idx == IDX_UDP_CHK) rx_udp_chk = w;
            if (idx < IP_HDR_LEN && idx != IDX_HDR_CHK) hdr_sum = ones_add(hdr_sum, w);
            if (idx >= IDX_PSEUDO && idx != IDX_UDP_CHK) udp_sum = ones_add(udp_sum, w);
        end
    endfunction

    function t_result judge();
        t_result     r;
        logic [15:0] s;
        logic [15:0] calc;
        logic [15:0] want_ulen;
        r.payload_len = '0;
        want_ulen = total_len - IP_HDR_LEN;
        if (byte_count < MIN_FRAME) begin
            r.status = ST_SHORT;
        end else if (byte_count < total_len) begin
            r.status = ST_TRUNCATED;
        end else if (proto != UDP_PROTO || ver_ihl[7:4] != IP_VERSION ||
                     ver_ihl[3:0] != IP_IHL || dst_port != client_port ||
                     udp_len != want_ulen || total_len < MIN_FRAME) begin
            r.status = ST_UNRELATED;
        end else if (~hdr_sum != rx_hdr_chk) begin
            r.status = ST_BAD_IPCHK;
        end else begin
            s = ones_add(udp_sum, 16'(UDP_PROTO));
            s = ones_add(s, udp_len);
            // odd length: the dangling byte counts as a word with a zero low byte
            if (total_len[0]) s = ones_add(s, {held_hi, 8'h00});
            calc = ~s;
            if (rx_udp_chk != 16'h0 && rx_udp_chk != calc &&
                !(calc == 16'h0 && rx_udp_chk == ALL_ONES)) begin
                r.status = ST_BAD_UDPCHK;
            end else begin
                r.status = ST_OK;
                r.payload_len = total_len - MIN_FRAME;
            end
        end
        return r;
    endfunction

    function void note_byte(logic [7:0] d, logic last);
        logic [15:0] idx;
        if (byte_count < max_len) begin
            idx = byte_count;
            byte_count = byte_count + 16'd1;
            // the first four bytes always count, they carry total length
            if (idx < 16'd4 || idx < total_len) take_byte(idx, d);
        end
        if (last) begin
            expected.push_back(judge());
            clear_frame();
        end
    endfunction

    function void check_verdict(logic [23:0] got);
        t_result exp;
        if (expected.size() == 0) begin
            $error("verdict with none pending: status %0d payload_len %0d",
                   got[2:0], got[18:3]);
            errors++;
            return;
        end
        exp = expected.pop_front();
        if (got[2:0] !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got[2:0]);
            errors++;
        end
        if (got[18:3] !== exp.payload_len) begin
            $error("payload_len: expected %0d, got %0d", exp.payload_len, got[18:3]);
            errors++;
        end
        if (got[23:19] !== 5'd0) begin
            $error("pad: expected 0, got %0d", got[23:19]);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 5000;

    typedef enum int {
        FR_GOOD, FR_ZERO_CHK, FR_CALC_ZERO, FR_BAD_IPCHK, FR_BAD_UDPCHK,
        FR_BAD_PROTO, FR_BAD_VER, FR_BAD_IHL, FR_BAD_PORT, FR_BAD_ULEN,
        FR_TINY_TOTAL, FR_TRUNC, FR_TRAILING, FR_SHORT, FR_NOISE
    } t_frame_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata = '0;
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [23:0]          o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    verdict_board board;
    logic [7:0]   frame_q[$];
    int           rx_hold = 0;
    bit           no_idle = 1'b0;
    int           stall_cycles = 0;

    ipv4_udp_receive_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // verdict receiver, with random and forced back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) board.check_verdict(o_m_tdata);
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_m_tready <= 1'b0;
            end else if (no_idle) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] nz_bits();
        return 8'($urandom_range(255, 1));
    endfunction

    // idx names the low byte of a big-endian 16-bit field
    function automatic void put16(int idx, logic [15:0] val);
        frame_q[idx - 1] = val[15:8];
        frame_q[idx] = val[7:0];
    endfunction

    function automatic logic [15:0] word_sum(int lo, int hi);
        logic [15:0] s;
        logic [7:0]  lo_b;
        s = '0;
        for (int i = lo; i < hi; i += 2) begin
            lo_b = (i + 1 < hi) ? frame_q[i + 1] : 8'h00;
            s = oc_add(s, {frame_q[i], lo_b});
        end
        return s;
    endfunction

    function automatic logic [15:0] udp_sum_of(int tot, logic [15:0] ulen);
        return oc_add(oc_add(word_sum(int'(IDX_PSEUDO), tot), 16'(UDP_PROTO)), ulen);
    endfunction

    // well-formed datagram to the client port, with random addresses, source port and payload
    function automatic void build_udp(int plen, bit zero_calc);
        int          tot;
        logic [15:0] ulen;
        logic [15:0] s;
        tot = 28 + plen;
        frame_q.delete();
        repeat (tot) frame_q.push_back(8'($urandom));
        frame_q[IDX_VER_IHL] = {IP_VERSION, IP_IHL};
        put16(IDX_TOT_LEN, 16'(tot));
        frame_q[IDX_PROTO] = UDP_PROTO;
        put16(IDX_HDR_CHK, 16'h0);
        put16(IDX_DST_PORT, board.client_port);
        ulen = 16'(tot) - IP_HDR_LEN;
        put16(IDX_UDP_LEN, ulen);
        put16(IDX_UDP_CHK, 16'h0);
        put16(IDX_HDR_CHK, ~word_sum(0, int'(IP_HDR_LEN)));
        // first payload word chosen so the computed checksum comes out zero
        if (zero_calc && plen >= 2) begin
            put16(29, 16'h0);
            put16(29, ~udp_sum_of(tot, ulen));
        end
        s = ~udp_sum_of(tot, ulen);
        put16(IDX_UDP_CHK, (s == 16'h0) ? ALL_ONES : s);
    endfunction

    function automatic void make_frame(t_frame_kind kind, int plen);
        logic [15:0] tl;
        build_udp(plen, kind == FR_CALC_ZERO);
        case (kind)
            FR_ZERO_CHK:   put16(IDX_UDP_CHK, 16'h0);
            FR_BAD_IPCHK:  frame_q[IDX_HDR_CHK - $urandom_range(1)] ^= nz_bits();
            FR_BAD_UDPCHK: frame_q[$urandom_range(frame_q.size() - 1, 12)] ^= nz_bits();
            FR_BAD_PROTO: begin
                do frame_q[IDX_PROTO] = 8'($urandom);
                while (frame_q[IDX_PROTO] == UDP_PROTO);
            end
            FR_BAD_VER:    frame_q[IDX_VER_IHL] ^= {4'($urandom_range(15, 1)), 4'h0};
            FR_BAD_IHL:    frame_q[IDX_VER_IHL] ^= {4'h0, 4'($urandom_range(15, 1))};
            FR_BAD_PORT:   frame_q[IDX_DST_PORT - $urandom_range(1)] ^= nz_bits();
            FR_BAD_ULEN:   frame_q[IDX_UDP_LEN - $urandom_range(1)] ^= nz_bits();
            FR_TINY_TOTAL: begin
                // consistent UDP length, but too small for a UDP header
                tl = 16'($urandom_range(27));
                put16(IDX_TOT_LEN, tl);
                put16(IDX_UDP_LEN, tl - IP_HDR_LEN);
            end
            FR_TRUNC: repeat ($urandom_range(frame_q.size() - 1, 1)) void'(frame_q.pop_back());
            FR_TRAILING: repeat ($urandom_range(8, 1)) frame_q.push_back(8'($urandom));
            FR_SHORT: begin
                frame_q.delete();
                repeat ($urandom_range(27, 1)) frame_q.push_back(8'($urandom));
            end
            FR_NOISE: begin
                frame_q.delete();
                repeat ($urandom_range(64, 1)) frame_q.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    task automatic send_byte(logic [7:0] d, logic last);
        while (!no_idle && $urandom_range(99) < 15) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_byte(d, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // sender pauses until every pending verdict is out and the pipeline is empty
    task automatic drain();
        i_s_tvalid <= 1'b0;
        i_s_tlast <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(logic [15:0] port, logic [15:0] max_len);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CLIENT_PORT;
        i_cfg_data <= port;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(CFG_CLIENT_PORT, port);
        i_cfg_index <= CFG_MAX_LEN;
        i_cfg_data <= max_len;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(CFG_MAX_LEN, max_len);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] port, logic [15:0] max_len, int budget,
                             bit quiet, int hold);
        int          sent;
        int          plen;
        t_frame_kind kind;
        drain();
        load_config(port, max_len);
        no_idle = quiet;
        rx_hold = hold;
        sent = 0;
        while (sent < budget) begin
            plen = ($urandom_range(99) < 90) ? $urandom_range(24) : $urandom_range(80);
            if ($urandom_range(99) < 45) kind = FR_GOOD;
            else kind = t_frame_kind'($urandom_range(FR_NOISE, FR_ZERO_CHK));
            make_frame(kind, plen);
            sent += frame_q.size();
            send_frame();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each frame kind once under reset settings, plus empty and odd payloads
        make_frame(FR_GOOD, 0);
        send_frame();
        make_frame(FR_GOOD, 5);
        send_frame();
        for (int k = FR_GOOD; k <= FR_NOISE; k++) begin
            make_frame(t_frame_kind'(k), $urandom_range(9, 2));
            send_frame();
        end

        run_phase(16'h0000, 16'd28, 150, 1'b0, 0);
        run_phase(16'hffff, 16'hffff, 250, 1'b0, 500);
        run_phase(16'($urandom), 16'($urandom_range(60, 29)), 200, 1'b1, 0);
        // below the minimum frame every verdict is too short
        run_phase(16'($urandom), 16'd10, 80, 1'b0, 0);
        run_phase(CLIENT_PORT_RST, MAX_LEN_RST, 250, 1'b0, 0);

        drain();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
